// ----- rtl/pullback_entry_exit_signal_core_assert.svh -----
// Assertion macros for the top RTL file of the pullback signal core.
// PBES_ASSERT_IMP checks a same-cycle implication, PBES_ASSERT_NEXT one into the next cycle.
`ifndef PULLBACK_ENTRY_EXIT_SIGNAL_CORE_ASSERT_SVH
`define PULLBACK_ENTRY_EXIT_SIGNAL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PBES_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PBES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PBES_ASSERT_IMP(lbl, ante, cons, msg)
`define PBES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/pbes_pkg.sv -----
`default_nettype none
package pbes_pkg;
	localparam int SHORT_WINDOW  = 20;
	localparam int LONG_WINDOW   = 60;
	localparam int HISTORY_LIMIT = 180;

	localparam int SYM_W     = 16;
	localparam int CLOSE_W   = 32;
	localparam int VOL_W     = 40;
	localparam int QTY_W     = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int MODE_W    = 6;
	localparam int STOP_W    = 14;
	localparam int PROFIT_W  = 17;
	localparam int DAYS_W    = 8;
	localparam int KIND_W    = 2;
	localparam int REASON_W  = 3;

	localparam int HELD_W = $clog2(LONG_WINDOW + 2);
	localparam int RUN_W  = $clog2(HISTORY_LIMIT);
	localparam int SSUM_W = CLOSE_W + $clog2(SHORT_WINDOW);
	localparam int LSUM_W = CLOSE_W + $clog2(LONG_WINDOW);
	localparam int VSUM_W = VOL_W + $clog2(SHORT_WINDOW);
	// Wide enough for every moving-average and volume cross product.
	localparam int PROD_W = VSUM_W + 8;
	// Signed width of the profit products (C - E) * 10000 and threshold * E.
	localparam int PFT_W  = CLOSE_W + PROFIT_W + 2;

	// Mode flag bit positions.
	localparam int MODE_UP      = 0;
	localparam int MODE_NEAR    = 1;
	localparam int MODE_SHRINK  = 2;
	localparam int MODE_BREAK   = 3;
	localparam int MODE_PARTIAL = 4;
	localparam int MODE_PERMIT  = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYMBOL, CFG_LOT, CFG_MODE, CFG_STOP,
		CFG_SURGE, CFG_TAKE, CFG_RUN_MIN, CFG_RUN_MAX
	} cfg_idx_t;

	typedef enum logic [KIND_W-1:0] {KIND_BUY, KIND_STOP, KIND_TAKE} kind_t;

	typedef enum logic [REASON_W-1:0] {
		RSN_ENTRY, RSN_BREAK, RSN_STOP, RSN_SURGE, RSN_PROFIT
	} reason_t;

	typedef struct packed {
		logic [CLOSE_W-1:0] close;
		logic [VOL_W-1:0]   volume;
	} bar_t;

	typedef struct packed {
		logic [CLOSE_W-1:0] prev_close;
		logic [CLOSE_W-1:0] short_close;
		logic [VOL_W-1:0]   short_volume;
		logic [CLOSE_W-1:0] long_close;
	} taps_t;
endpackage
`default_nettype wire

// ----- rtl/pbes_if.sv -----
`default_nettype none
interface pbes_bar_if import pbes_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SYM_W-1:0]   symbol_id;
	logic [CLOSE_W-1:0] close_price;
	logic [VOL_W-1:0]   bar_volume;
	modport source(output valid, symbol_id, close_price, bar_volume, input ready);
	modport sink(input valid, symbol_id, close_price, bar_volume, output ready);
endinterface

interface pbes_sig_if import pbes_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   signal_kind;
	logic [REASON_W-1:0] reason_code;
	logic [CLOSE_W-1:0]  signal_price;
	logic [QTY_W-1:0]    signal_quantity;
	modport source(output valid, signal_kind, reason_code, signal_price, signal_quantity,
		input ready);
	modport sink(input valid, signal_kind, reason_code, signal_price, signal_quantity,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/pbes_cell.sv -----
`default_nettype none
// One bar of history; takes its neighbor's bar on every shift.
module pbes_cell import pbes_pkg::*; (
	input  wire  clk,
	input  wire  shift,
	input  bar_t d,
	output bar_t q
);
	bar_t bar_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			bar_q <= d;
		end
	end

	assign q = bar_q;
endmodule
`default_nettype wire

// ----- rtl/pbes_chain.sv -----
`default_nettype none
// Row of history cells, newest bar in cell zero.
module pbes_chain import pbes_pkg::*; (
	input  wire   clk,
	input  wire   shift,
	input  bar_t  bar_in,
	output taps_t taps
);
	bar_t link [LONG_WINDOW+1];

	assign link[0] = bar_in;

	for (genvar k = 0; k < LONG_WINDOW; k++) begin : g_cell
		pbes_cell u_cell (
			.clk  (clk),
			.shift(shift),
			.d    (link[k]),
			.q    (link[k+1])
		);
	end

	assign taps.prev_close   = link[1].close;
	assign taps.short_close  = link[SHORT_WINDOW].close;
	assign taps.short_volume = link[SHORT_WINDOW].volume;
	assign taps.long_close   = link[LONG_WINDOW].close;
endmodule
`default_nettype wire

// ----- rtl/pullback_entry_exit_signal_core.sv -----
`default_nettype none
// Channel   Dir  Handshake      Payload
// bars      in   valid/ready    symbol_id, close_price, bar_volume
// signals   out  valid/ready    signal_kind, reason_code, signal_price, signal_quantity
// cfg       in   cfg_we         cfg_index, cfg_wdata (write only)
//
// A taken request passes through stage one and stage two, and its signal, if any, is
// then loaded into the output register; a new request can be taken every cycle unless
// the stages are blocked by a stalled output. The history chain shifts once per used bar.
// Reset sets the default configuration and clears sums, counters and position state; the
// history cells are never cleared, since a cell is only read once enough bars have passed through it.
// A stalled output holds the last stage; the earlier stages keep filling until blocked.
module pullback_entry_exit_signal_core import pbes_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	pbes_bar_if.sink            bars,
	pbes_sig_if.source          signals,
	input  wire                 cfg_we,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [CFG_W-1:0]     cfg_wdata
);
`include "pullback_entry_exit_signal_core_assert.svh"

	// Configuration registers.
	logic [SYM_W-1:0]    symbol_q;
	logic [QTY_W-1:0]    lot_q;
	logic [MODE_W-1:0]   mode_q;
	logic [STOP_W-1:0]   stop_q;
	logic [PROFIT_W-1:0] surge_q;
	logic [PROFIT_W-1:0] take_q;
	logic [DAYS_W-1:0]   run_min_q;
	logic [DAYS_W-1:0]   run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q  <= '0;
			lot_q     <= QTY_W'(100);
			mode_q    <= '0;
			stop_q    <= STOP_W'(800);
			surge_q   <= PROFIT_W'(2000);
			take_q    <= PROFIT_W'(3000);
			run_min_q <= DAYS_W'(1);
			run_max_q <= DAYS_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SYMBOL:  symbol_q  <= cfg_wdata[SYM_W-1:0];
				CFG_LOT:     lot_q     <= cfg_wdata[QTY_W-1:0];
				CFG_MODE:    mode_q    <= cfg_wdata[MODE_W-1:0];
				CFG_STOP:    stop_q    <= cfg_wdata[STOP_W-1:0];
				CFG_SURGE:   surge_q   <= cfg_wdata[PROFIT_W-1:0];
				CFG_TAKE:    take_q    <= cfg_wdata[PROFIT_W-1:0];
				CFG_RUN_MIN: run_min_q <= cfg_wdata[DAYS_W-1:0];
				CFG_RUN_MAX: run_max_q <= cfg_wdata[DAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline control. The decide stage fires when the output register is free or being
	// emptied; each earlier stage moves when the one after it can take it.
	logic vld_s1, vld_s2, out_vld_q;
	logic decide_go, s2_free, take_bar, use_bar;

	assign decide_go   = vld_s2 && (!out_vld_q || signals.ready);
	assign s2_free     = !vld_s2 || decide_go;
	assign bars.ready  = !vld_s1 || s2_free;
	assign take_bar    = bars.valid && bars.ready;
	// Bars of other symbols and bars without a price are taken and dropped.
	assign use_bar     = take_bar && bars.symbol_id == symbol_q && bars.close_price != '0;

	// History chain and running state, updated when a bar is used.
	taps_t taps;
	bar_t  new_bar;

	assign new_bar.close  = bars.close_price;
	assign new_bar.volume = bars.bar_volume;

	pbes_chain u_chain (
		.clk   (clk),
		.shift (use_bar),
		.bar_in(new_bar),
		.taps  (taps)
	);

	logic [HELD_W-1:0] held_q;
	logic [RUN_W-1:0]  run_q;
	logic [SSUM_W-1:0] short_q;
	logic [LSUM_W-1:0] long_q, prior_q;
	logic [VSUM_W-1:0] vsum_q;
	logic [CLOSE_W-1:0] close_s1;
	logic [VOL_W-1:0]   vol_s1;

	logic [RUN_W-1:0]  run_d;
	logic [SSUM_W-1:0] short_d;
	logic [LSUM_W-1:0] long_d;
	logic [VSUM_W-1:0] vsum_d;
	logic              full_short, full_long;

	assign full_short = held_q >= HELD_W'(SHORT_WINDOW);
	assign full_long  = held_q >= HELD_W'(LONG_WINDOW);

	always_comb begin
		run_d = run_q;
		if (held_q != '0) begin
			if (bars.close_price < taps.prev_close) begin
				if (run_q < RUN_W'(HISTORY_LIMIT - 1)) begin
					run_d = run_q + RUN_W'(1);
				end
			end else begin
				run_d = '0;
			end
		end
		short_d = short_q + SSUM_W'(bars.close_price)
			- (full_short ? SSUM_W'(taps.short_close) : SSUM_W'(0));
		vsum_d  = vsum_q + VSUM_W'(bars.bar_volume)
			- (full_short ? VSUM_W'(taps.short_volume) : VSUM_W'(0));
		long_d  = long_q + LSUM_W'(bars.close_price)
			- (full_long ? LSUM_W'(taps.long_close) : LSUM_W'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			run_q   <= '0;
			short_q <= '0;
			long_q  <= '0;
			prior_q <= '0;
			vsum_q  <= '0;
		end else if (use_bar) begin
			if (held_q < HELD_W'(LONG_WINDOW + 1)) begin
				held_q <= held_q + HELD_W'(1);
			end
			run_q   <= run_d;
			short_q <= short_d;
			long_q  <= long_d;
			prior_q <= long_q;
			vsum_q  <= vsum_d;
		end
	end

	// Stage one holds the bar whose sums sit in the state registers; the state cannot
	// move on while stage one is stalled, since no new bar is taken then.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bars.ready) begin
			vld_s1 <= use_bar;
		end
	end

	always_ff @(posedge clk) begin
		if (use_bar) begin
			close_s1 <= bars.close_price;
			vol_s1   <= bars.bar_volume;
		end
	end

	// Stage one to two: moving-average and volume cross products, reduced to flags.
	logic near_c, shrink_c, vbreak_c, below_c, up_c, window_c, elig_c;
	logic [PROD_W-1:0] c_ext, v_ext, vs_ext;

	assign c_ext  = PROD_W'(close_s1);
	assign v_ext  = PROD_W'(vol_s1);
	assign vs_ext = PROD_W'(vsum_q);

	assign near_c = !mode_q[MODE_NEAR]
		|| c_ext * PROD_W'(SHORT_WINDOW * 1000) <= PROD_W'(short_q) * PROD_W'(1015)
		|| c_ext * PROD_W'(LONG_WINDOW * 1000) <= PROD_W'(long_q) * PROD_W'(1015);
	assign shrink_c = !mode_q[MODE_SHRINK] || vsum_q == '0
		|| v_ext * PROD_W'(SHORT_WINDOW * 10) <= vs_ext * PROD_W'(9);
	assign vbreak_c = vsum_q == '0
		|| v_ext * PROD_W'(SHORT_WINDOW * 100) >= vs_ext * PROD_W'(115);
	assign below_c  = c_ext * PROD_W'(LONG_WINDOW) < PROD_W'(long_q);
	assign up_c     = !mode_q[MODE_UP]
		|| (held_q > HELD_W'(LONG_WINDOW) && long_q >= prior_q);
	assign window_c = RUN_W'(run_min_q) <= run_q && run_q <= RUN_W'(run_max_q);
	assign elig_c   = full_long;

	logic [CLOSE_W-1:0] close_s2;
	logic near_s2, shrink_s2, vbreak_s2, below_s2, up_s2, window_s2, elig_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && vld_s1) begin
			close_s2  <= close_s1;
			near_s2   <= near_c;
			shrink_s2 <= shrink_c;
			vbreak_s2 <= vbreak_c;
			below_s2  <= below_c;
			up_s2     <= up_c;
			window_s2 <= window_c;
			elig_s2   <= elig_c;
		end
	end

	// Decide stage: profit against the entry price, then the exit or entry rules.
	logic holding_q, partial_q;
	logic [CLOSE_W-1:0] entry_q;

	logic signed [CLOSE_W+1:0]  diff;
	logic signed [PFT_W-1:0]    num;
	logic [PFT_W-2:0]           stop_pe, surge_pe, take_pe;
	logic signed [PFT_W-1:0]    loss_sum;
	logic loss_hit, surge_hit, take_hit;

	assign diff     = $signed({2'b00, close_s2}) - $signed({2'b00, entry_q});
	assign num      = PFT_W'(diff) * $signed(PFT_W'(10000));
	assign stop_pe  = (PFT_W-1)'(stop_q) * (PFT_W-1)'(entry_q);
	assign surge_pe = (PFT_W-1)'(surge_q) * (PFT_W-1)'(entry_q);
	assign take_pe  = (PFT_W-1)'(take_q) * (PFT_W-1)'(entry_q);
	assign loss_sum = num + $signed({1'b0, stop_pe});

	// With no entry price the profit counts as zero, so only a zero threshold is met.
	assign loss_hit  = (entry_q == '0) ? (stop_q == '0) : (loss_sum <= 0);
	assign surge_hit = (entry_q == '0) ? (surge_q == '0) : (num >= $signed({1'b0, surge_pe}));
	assign take_hit  = (entry_q == '0) ? (take_q == '0) : (num >= $signed({1'b0, take_pe}));

	logic          fire;
	kind_t         kind_d;
	reason_t       reason_d;
	logic [QTY_W-1:0] qty_d;
	logic          holding_d, partial_d, enter_d;

	always_comb begin
		fire      = 1'b0;
		kind_d    = KIND_BUY;
		reason_d  = RSN_ENTRY;
		qty_d     = lot_q;
		holding_d = holding_q;
		partial_d = partial_q;
		enter_d   = 1'b0;
		if (elig_s2) begin
			if (holding_q) begin
				priority if (mode_q[MODE_BREAK] && below_s2 && vbreak_s2) begin
					fire      = 1'b1;
					kind_d    = KIND_STOP;
					reason_d  = RSN_BREAK;
					holding_d = 1'b0;
					partial_d = 1'b0;
				end else if (loss_hit) begin
					fire      = 1'b1;
					kind_d    = KIND_STOP;
					reason_d  = RSN_STOP;
					holding_d = 1'b0;
					partial_d = 1'b0;
				end else if (surge_hit && !partial_q) begin
					fire      = 1'b1;
					kind_d    = KIND_TAKE;
					reason_d  = RSN_SURGE;
					partial_d = mode_q[MODE_PARTIAL];
					holding_d = mode_q[MODE_PARTIAL];
					qty_d     = mode_q[MODE_PARTIAL] ? (lot_q >> 1) : lot_q;
				end else if (take_hit && !mode_q[MODE_PARTIAL]) begin
					fire      = 1'b1;
					kind_d    = KIND_TAKE;
					reason_d  = RSN_PROFIT;
					holding_d = 1'b0;
				end else begin
				end
			end else if (mode_q[MODE_PERMIT] && up_s2 && near_s2 && shrink_s2 && window_s2)
			begin
				fire      = 1'b1;
				holding_d = 1'b1;
				partial_d = 1'b0;
				enter_d   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			partial_q <= 1'b0;
			entry_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (decide_go) begin
				holding_q <= holding_d;
				partial_q <= partial_d;
				if (enter_d) begin
					entry_q <= close_s2;
				end
			end
			if (decide_go && fire) begin
				out_vld_q <= 1'b1;
			end else if (signals.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	logic [KIND_W-1:0]   kind_q;
	logic [REASON_W-1:0] reason_q;
	logic [CLOSE_W-1:0]  price_q;
	logic [QTY_W-1:0]    qty_q;

	always_ff @(posedge clk) begin
		if (decide_go && fire) begin
			kind_q   <= kind_d;
			reason_q <= reason_d;
			price_q  <= close_s2;
			qty_q    <= qty_d;
		end
	end

	assign signals.valid           = out_vld_q;
	assign signals.signal_kind     = kind_q;
	assign signals.reason_code     = reason_q;
	assign signals.signal_price    = price_q;
	assign signals.signal_quantity = qty_q;

	`PBES_ASSERT_IMP(a_held_cap, 1'b1, held_q <= HELD_W'(LONG_WINDOW + 1), "bar count overran")
	`PBES_ASSERT_IMP(a_run_cap, 1'b1, run_q <= RUN_W'(HISTORY_LIMIT - 1), "decline run overran")
	`PBES_ASSERT_NEXT(a_out_hold, out_vld_q && !signals.ready,
		out_vld_q && $stable(price_q), "stalled signal did not hold")
	`PBES_ASSERT_NEXT(a_buy_holds, decide_go && fire && kind_d == KIND_BUY,
		holding_q && entry_q != '0, "entry did not open a position")
endmodule
`default_nettype wire

// ----- tb/pullback_entry_exit_signal_core_tb.sv -----
`default_nettype none
// Testbench for the pullback entry/exit signal core.
// Bars are sent on the bars channel, signals are collected on the signals channel.
// A scoreboard object keeps its own copy of the trading state and predicts the signal,
// if any, that each accepted bar request should produce.
module pullback_entry_exit_signal_core_tb;
	import pbes_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	// The core holds a signal once its request has passed the pipeline stages; leave generous slack.
	localparam int SETTLE_CYCLES  = 12;
	localparam int EXP_DEPTH      = 64;

	typedef struct {
		kind_t              kind;
		reason_t            reason;
		logic [CLOSE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} trade_signal_t;

	// Predicts the trading signals and holds those not yet seen on the output.
	class signal_scoreboard;
		logic [SYM_W-1:0]    watched;
		logic [QTY_W-1:0]    lot;
		logic [MODE_W-1:0]   mode;
		logic [STOP_W-1:0]   stop_bp;
		logic [PROFIT_W-1:0] surge_bp;
		logic [PROFIT_W-1:0] take_bp;
		logic [DAYS_W-1:0]   run_min;
		logic [DAYS_W-1:0]   run_max;

		logic [CLOSE_W-1:0]  closes[64];
		logic [VOL_W-1:0]    vols[32];
		logic [5:0]          wpos;
		int unsigned         held;
		longint unsigned     ssum, lsum, prior_lsum, vsum;
		int unsigned         decl_run;
		bit                  in_position, partial_taken;
		longint              entry;
		// Predicted signals in order, oldest at exp_head.
		trade_signal_t       expected_signals[EXP_DEPTH];
		int unsigned         exp_head, exp_count;

		function new();
			watched = 0; lot = 100; mode = 0; stop_bp = 800;
			surge_bp = 2000; take_bp = 3000; run_min = 1; run_max = 5;
			wpos = 0; held = 0; ssum = 0; lsum = 0; prior_lsum = 0; vsum = 0;
			decl_run = 0; in_position = 0; partial_taken = 0; entry = 0;
			exp_head = 0; exp_count = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_SYMBOL:  watched = val[SYM_W-1:0];
				CFG_LOT:     lot = val[QTY_W-1:0];
				CFG_MODE:    mode = val[MODE_W-1:0];
				CFG_STOP:    stop_bp = val[STOP_W-1:0];
				CFG_SURGE:   surge_bp = val[PROFIT_W-1:0];
				CFG_TAKE:    take_bp = val[PROFIT_W-1:0];
				CFG_RUN_MIN: run_min = val[DAYS_W-1:0];
				CFG_RUN_MAX: run_max = val[DAYS_W-1:0];
				default: ;
			endcase
		endfunction

		// Gain against the entry in basis points compared exactly with a threshold.
		function bit gain_reaches(longint c, longint thr);
			longint num, den;
			num = (entry != 0) ? (c - entry) * 10000 : 0;
			den = (entry != 0) ? entry : 1;
			return num >= thr * den;
		endfunction

		function bit loss_reaches(longint c, longint thr);
			longint num, den;
			num = (entry != 0) ? (c - entry) * 10000 : 0;
			den = (entry != 0) ? entry : 1;
			return num + thr * den <= 0;
		endfunction

		function void push(kind_t k, reason_t r, logic [CLOSE_W-1:0] p, logic [QTY_W-1:0] q);
			trade_signal_t s;
			s.kind = k; s.reason = r; s.price = p; s.qty = q;
			if (exp_count < EXP_DEPTH) begin
				expected_signals[(exp_head + exp_count) % EXP_DEPTH] = s;
				exp_count++;
			end
		endfunction

		function void note_bar(logic [SYM_W-1:0] sym, logic [CLOSE_W-1:0] c,
				logic [VOL_W-1:0] v);
			longint unsigned cl, vl;
			logic [5:0] idx;
			bit partial_en, vbreak, up, near, shrink, in_window;
			if (sym != watched || c == 0)
				return;
			cl = c;
			vl = v;
			if (held > 0) begin
				idx = wpos - 6'd1;
				if (c < closes[idx]) begin
					if (decl_run < HISTORY_LIMIT - 1)
						decl_run++;
				end else begin
					decl_run = 0;
				end
			end
			prior_lsum = lsum;
			if (held >= SHORT_WINDOW) begin
				idx = wpos - 6'(SHORT_WINDOW);
				ssum -= closes[idx];
				vsum -= vols[idx[4:0]];
			end
			if (held >= LONG_WINDOW) begin
				idx = wpos - 6'(LONG_WINDOW);
				lsum -= closes[idx];
			end
			ssum += cl;
			lsum += cl;
			vsum += vl;
			closes[wpos] = c;
			vols[wpos[4:0]] = v;
			wpos = wpos + 6'd1;
			if (held < LONG_WINDOW + 1)
				held++;
			if (held < LONG_WINDOW)
				return;

			if (in_position) begin
				partial_en = mode[MODE_PARTIAL];
				vbreak = vsum == 0 || vl * SHORT_WINDOW * 100 >= vsum * 115;
				if (mode[MODE_BREAK] && cl * LONG_WINDOW < lsum && vbreak) begin
					in_position = 0; partial_taken = 0;
					push(KIND_STOP, RSN_BREAK, c, lot);
				end else if (loss_reaches(longint'(cl), longint'(stop_bp))) begin
					in_position = 0; partial_taken = 0;
					push(KIND_STOP, RSN_STOP, c, lot);
				end else if (gain_reaches(longint'(cl), longint'(surge_bp)) && !partial_taken) begin
					// With partial profit enabled only half the lot is sold and the
					// position stays open.
					partial_taken = partial_en;
					if (!partial_en)
						in_position = 0;
					push(KIND_TAKE, RSN_SURGE, c, partial_en ? lot >> 1 : lot);
				end else if (gain_reaches(longint'(cl), longint'(take_bp)) && !partial_en) begin
					in_position = 0;
					push(KIND_TAKE, RSN_PROFIT, c, lot);
				end
				return;
			end

			up = !mode[MODE_UP] || (held > LONG_WINDOW && lsum >= prior_lsum);
			near = !mode[MODE_NEAR] || cl * SHORT_WINDOW * 1000 <= ssum * 1015 ||
				cl * LONG_WINDOW * 1000 <= lsum * 1015;
			shrink = !mode[MODE_SHRINK] || vsum == 0 || vl * SHORT_WINDOW * 10 <= vsum * 9;
			in_window = decl_run >= run_min && decl_run <= run_max;
			if (mode[MODE_PERMIT] && up && near && shrink && in_window) begin
				in_position = 1;
				partial_taken = 0;
				entry = longint'(cl);
				push(KIND_BUY, RSN_ENTRY, c, lot);
			end
		endfunction

		// Compares one output signal with the oldest prediction; returns 0 and a
		// description on a mismatch.
		function bit check_signal(trade_signal_t got, output string msg);
			trade_signal_t want;
			if (exp_count == 0) begin
				msg = $sformatf("unexpected signal kind=%0d reason=%0d price=%0d qty=%0d",
					got.kind, got.reason, got.price, got.qty);
				return 0;
			end
			want = expected_signals[exp_head];
			exp_head = (exp_head + 1) % EXP_DEPTH;
			exp_count--;
			if (got.kind !== want.kind || got.reason !== want.reason ||
					got.price !== want.price || got.qty !== want.qty) begin
				msg = $sformatf("signal got %0d/%0d/%0d/%0d expected %0d/%0d/%0d/%0d",
					got.kind, got.reason, got.price, got.qty,
					want.kind, want.reason, want.price, want.qty);
				return 0;
			end
			msg = "";
			return 1;
		endfunction

		function int pending();
			return int'(exp_count);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	pbes_bar_if bars();
	pbes_sig_if signals();

	pullback_entry_exit_signal_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bars(bars.sink),
		.signals(signals.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	signal_scoreboard sb;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	// Current level of the simulated market; the random walk moves it bar by bar.
	longint market_px;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Every input is known from time zero; reset is asserted only once.
	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_SYMBOL;
		cfg_wdata = 0;
		bars.valid = 0;
		bars.symbol_id = 0;
		bars.close_price = 0;
		bars.bar_volume = 0;
		signals.ready = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// The receiver stalls at random according to the current phase.
	always @(negedge clk) begin
		if (!arst_n)
			signals.ready = 0;
		else
			signals.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Requests and signals are sampled at the rising edge, before the core updates.
	always @(posedge clk) begin
		trade_signal_t got;
		string msg;
		if (arst_n) begin
			if (bars.valid && bars.ready)
				sb.note_bar(bars.symbol_id, bars.close_price, bars.bar_volume);
			if (signals.valid && signals.ready) begin
				got.kind = kind_t'(signals.signal_kind);
				got.reason = reason_t'(signals.reason_code);
				got.price = signals.signal_price;
				got.qty = signals.signal_quantity;
				if (!sb.check_signal(got, msg))
					report_mismatch(msg);
			end
		end
	end

	// Ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((bars.valid && bars.ready) || (signals.valid && signals.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d signals outstanding", sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Holds further requests back until every predicted signal has come out, then
	// lets the pipeline settle in case the last bar produced nothing.
	task automatic drain_signals();
		@(negedge clk);
		bars.valid = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One bar request; the sender may idle for a while first.
	task automatic send_bar(logic [SYM_W-1:0] sym, logic [CLOSE_W-1:0] c, logic [VOL_W-1:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			bars.valid = 0;
		end
		@(negedge clk);
		bars.valid = 1;
		bars.symbol_id = sym;
		bars.close_price = c;
		bars.bar_volume = v;
		do
			@(posedge clk);
		while (!bars.ready);
	endtask

	task automatic configure(logic [SYM_W-1:0] sym, logic [QTY_W-1:0] lot,
			logic [MODE_W-1:0] mode, int unsigned stop, int unsigned surge,
			int unsigned take, int unsigned rmin, int unsigned rmax);
		drain_signals();
		write_reg(CFG_SYMBOL, CFG_W'(sym));
		write_reg(CFG_LOT, CFG_W'(lot));
		write_reg(CFG_MODE, CFG_W'(mode));
		write_reg(CFG_STOP, CFG_W'(stop));
		write_reg(CFG_SURGE, CFG_W'(surge));
		write_reg(CFG_TAKE, CFG_W'(take));
		write_reg(CFG_RUN_MIN, CFG_W'(rmin));
		write_reg(CFG_RUN_MAX, CFG_W'(rmax));
	endtask

	// Mostly a random walk on the watched symbol, so that the averages settle and
	// entries and exits actually happen; the rest is noise the core must ignore or
	// absorb: foreign symbols, zero closes and full-range values.
	task automatic random_bar();
		int unsigned r;
		logic [SYM_W-1:0] sym;
		logic [CLOSE_W-1:0] c;
		logic [VOL_W-1:0] v;
		longint step;
		r = $urandom_range(99);
		sym = sb.watched;
		v = VOL_W'($urandom_range(20000, 200000));
		if ($urandom_range(9) == 0)
			v = VOL_W'($urandom_range(0, 5000));
		else if ($urandom_range(9) == 0)
			v = VOL_W'($urandom_range(400000, 2000000));
		if (r < 5) begin
			sym = SYM_W'($urandom);
			if (sym == sb.watched)
				sym = ~sym;
			c = $urandom;
			v = VOL_W'({$urandom, $urandom});
		end else if (r < 8) begin
			c = 0;
		end else if (r < 10) begin
			c = $urandom;
			v = VOL_W'({$urandom, $urandom});
		end else begin
			// Steps of up to four percent either way, in tenths of a percent.
			step = longint'($urandom_range(80)) - 40;
			market_px = market_px + market_px * step / 1000;
			if (market_px < 100)
				market_px = 100;
			if (market_px > 1000000000)
				market_px = 1000000000;
			c = CLOSE_W'(market_px);
		end
		send_bar(sym, c, v);
	endtask

	task automatic random_phase(int unsigned count, int unsigned idle, int unsigned stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) random_bar();
	endtask

	initial begin
		sb = new();
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		market_px = 50000;
		@(posedge arst_n);

		// Directed bars under the reset settings: entries are not permitted, so only
		// the sums and the decline run move.
		send_bar(16'h0000, 32'd0, 40'd5);                      // zero close ignored
		send_bar(16'hFFFF, 32'd1000, 40'd5);                   // foreign symbol ignored
		send_bar(16'h0000, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);   // largest close and volume
		send_bar(16'h0000, 32'd1, 40'd0);                      // smallest close, no volume
		send_bar(16'h0000, 32'd1, 40'd0);                      // equal close ends the run
		send_bar(16'h0000, 32'hFFFF_FFFF, 40'd1);
		send_bar(16'h5A5A, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
		send_bar(16'h0000, 32'h8000_0000, 40'h80_0000_0000);
		send_bar(16'h0000, 32'h7FFF_FFFF, 40'h7F_FFFF_FFFF);
		repeat (12) begin
			market_px = market_px - market_px / 50;
			send_bar(16'h0000, CLOSE_W'(market_px), 40'd1000);
		end

		// Everything enabled with the reset thresholds, no idling.
		configure(16'h0000, 24'd100, 6'h3F, 800, 2000, 3000, 1, 5);
		random_phase(110, 0, 0);

		// A new watched symbol, the largest lot, no break or partial exits; tight
		// thresholds so that trades close quickly. The sender idles.
		configure(16'hFFFF, 24'hFF_FFFF, 6'h27, 300, 500, 700, 1, 5);
		random_phase(110, 68, 0);

		// Stop beyond one hundred percent can never fire; surge at zero fires as
		// soon as the price is at or over the entry; any decline run is accepted.
		configure(16'h1234, 24'd1, 6'h38, 12000, 0, 100000, 0, 255);
		random_phase(110, 0, 68);

		// Minimum above maximum: no entry may happen, open positions still exit.
		configure(16'h1234, 24'd0, 6'h20, 0, 100000, 0, 5, 2);
		random_phase(60, 33, 33);

		// Only a zero decline run allowed, plain thresholds, both sides idling.
		configure(16'h0000, 24'd3, 6'h21, 10000, 1000, 1500, 0, 0);
		random_phase(50, 33, 33);

		configure(16'h0000, 24'd101, 6'h30, 500, 600, 1200, 0, 3);
		random_phase(100, 0, 0);

		drain_signals();
		if (mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
